// ===== src/slfd_pkg.sv =====
`default_nettype none
package slfd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegSyncFirst  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSyncSecond = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxLen     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCmdChan    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDataChan   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCmdEn      = 3'd5;
  localparam logic [CfgIdxW-1:0] RegDataEn     = 3'd6;

  localparam logic RouteCmd  = 1'b0;
  localparam logic RouteData = 1'b1;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CHAN    = 3'd2,
    PH_LENLO   = 3'd3,
    PH_LENHI   = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_len;
    logic [7:0]  command_channel_id;
    logic [7:0]  data_channel_id;
    logic        command_route_enable;
    logic        data_route_enable;
  } cfg_t;

  typedef struct packed {
    logic        route;
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic        frame_last;
    logic [15:0] frame_length;
  } result_t;

endpackage
`default_nettype wire

// ===== src/slfd_cfg.sv =====
`default_nettype none
module slfd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [slfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [slfd_pkg::CfgDataW-1:0]  cfg_data_i,
  output slfd_pkg::cfg_t                      cfg_o
);
  import slfd_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSyncFirst:  cfg_d.sync_first           = cfg_data_i[7:0];
        RegSyncSecond: cfg_d.sync_second          = cfg_data_i[7:0];
        RegMaxLen:     cfg_d.max_payload_len      = cfg_data_i;
        RegCmdChan:    cfg_d.command_channel_id   = cfg_data_i[7:0];
        RegDataChan:   cfg_d.data_channel_id      = cfg_data_i[7:0];
        RegCmdEn:      cfg_d.command_route_enable = cfg_data_i[0];
        RegDataEn:     cfg_d.data_route_enable    = cfg_data_i[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first           <= 8'd0;
      cfg_q.sync_second          <= 8'd0;
      cfg_q.max_payload_len      <= 16'd1024;
      cfg_q.command_channel_id   <= 8'd0;
      cfg_q.data_channel_id      <= 8'd1;
      cfg_q.command_route_enable <= 1'b0;
      cfg_q.data_route_enable    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== src/slfd_parser.sv =====
`default_nettype none
module slfd_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire slfd_pkg::cfg_t cfg_i,
  output logic               res_valid_o,
  output slfd_pkg::result_t  res_o
);
  import slfd_pkg::*;

  phase_e      phase_d, phase_q;
  logic [7:0]  chan_d, chan_q;
  logic [15:0] len_d, len_q;
  logic [15:0] cnt_d, cnt_q;

  logic [15:0] len_full;
  logic [15:0] cnt_inc;
  logic        hit_cmd, hit_data, routed, route_sel;

  assign len_full  = {rx_byte_i, len_q[7:0]};
  assign cnt_inc   = cnt_q + 16'd1;
  // Command wins when the channel matches both enabled routes
  assign hit_cmd   = (chan_q == cfg_i.command_channel_id) && cfg_i.command_route_enable;
  assign hit_data  = (chan_q == cfg_i.data_channel_id) && cfg_i.data_route_enable;
  assign routed    = hit_cmd || hit_data;
  assign route_sel = hit_cmd ? RouteCmd : RouteData;

  // Next state
  always_comb begin
    phase_d = phase_q;
    chan_d  = chan_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      case (phase_q)
        PH_SYNC2: begin
          if (rx_byte_i == cfg_i.sync_second) begin
            phase_d = PH_CHAN;
          end else if (rx_byte_i == cfg_i.sync_first) begin
            phase_d = PH_SYNC2;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_CHAN: begin
          chan_d  = rx_byte_i;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          len_d   = {8'd0, rx_byte_i};
          phase_d = PH_LENHI;
        end
        PH_LENHI: begin
          len_d = len_full;
          if (len_full > cfg_i.max_payload_len) begin
            phase_d = PH_SYNC1;
          end else begin
            cnt_d   = 16'd0;
            phase_d = (len_full == 16'd0) ? PH_SYNC1 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= len_q) begin
            phase_d = PH_SYNC1;
          end
        end
        default: begin
          phase_d = (rx_byte_i == cfg_i.sync_first) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.route        = route_sel;
    res_o.payload_byte = 8'd0;
    res_o.byte_present = 1'b0;
    res_o.frame_last   = 1'b1;
    res_o.frame_length = 16'd0;
    case (phase_q)
      PH_LENHI: begin
        res_valid_o = step_i && routed && (len_full == 16'd0);
      end
      PH_PAYLOAD: begin
        res_valid_o        = step_i && routed;
        res_o.payload_byte = rx_byte_i;
        res_o.byte_present = 1'b1;
        res_o.frame_last   = cnt_inc >= len_q;
        res_o.frame_length = len_q;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC1;
      chan_q  <= 8'd0;
      len_q   <= 16'd0;
      cnt_q   <= 16'd0;
    end else begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_res_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> step_i)
    else $error("result raised without a transfer");

  a_payload_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (len_q != 16'd0) && (cnt_q < len_q))
    else $error("payload count out of range");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.frame_last) |=> (phase_q == PH_SYNC1))
    else $error("frame did not end after last result");
`endif

endmodule
`default_nettype wire

// ===== src/slfd_out_reg.sv =====
`default_nettype none
module slfd_out_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  wire slfd_pkg::result_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output slfd_pkg::result_t  res_o
);
  import slfd_pkg::*;

  logic    valid_d, valid_q;
  result_t res_q;

  // Room for a new result when empty or when the held one leaves this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== src/sync_length_frame_deframer.sv =====
`default_nettype none
// Channel | Handshake              | Payload
// in      | in_valid_i/in_ready_o  | rx_byte_i
// out     | out_valid_o/out_ready_i| route_o payload_byte_o byte_present_o
//         |                        | frame_last_o frame_length_o
// cfg     | cfg_we_i (no wait)     | cfg_idx_i cfg_data_i
//
// One byte per cycle while in_ready_o is high: each transfer updates the
// header state in a single pass and loads at most one result into the
// output register, and out_valid_o rises in the cycle after that transfer.
// Reset (asynchronous, active low) restores the register defaults and the
// sync hunt. Input stalls only while a result is held and out_ready_i is low.
module sync_length_frame_deframer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               route_o,
  output logic [7:0]                         payload_byte_o,
  output logic                               byte_present_o,
  output logic                               frame_last_o,
  output logic [15:0]                        frame_length_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [slfd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [slfd_pkg::CfgDataW-1:0] cfg_data_i
);
  import slfd_pkg::*;

  cfg_t    cfg;
  result_t res_new, res_out;
  logic    res_valid;
  logic    out_free;
  logic    step;

  // Take a byte whenever the output register can absorb its result
  assign in_ready_o = out_free;
  assign step       = in_valid_i && out_free;

  slfd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Sync hunt, header decode, payload counting and route choice
  slfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  // Hold a finished result until the consumer takes the transfer
  slfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_new),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign route_o        = res_out.route;
  assign payload_byte_o = res_out.payload_byte;
  assign byte_present_o = res_out.byte_present;
  assign frame_last_o   = res_out.frame_last;
  assign frame_length_o = res_out.frame_length;

endmodule
`default_nettype wire
